FILE: src/sha1md_pkg.sv
`timescale 1ns / 1ps

package sha1md_pkg;

  // what the front hands to the core for each item that matters
  typedef enum logic [1:0] {
    CMD_BYTE     = 2'd0,
    CMD_BYTE_END = 2'd1,
    CMD_END      = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
  } cmd_t;

  localparam int DIGEST_WORDS = 5;
  localparam logic [2:0] LAST_WORD_NUM = 3'd4;

  // finished digest passed from the core to the output buffer
  typedef struct packed {
    logic                               valid;
    logic [DIGEST_WORDS-1:0][31:0]      words;
  } digest_t;

endpackage

FILE: src/sha1md_front.sv
`timescale 1ns / 1ps

module sha1md_front
  import sha1md_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  input  logic       in_no_data,
  output logic       q_push,
  output cmd_t       q_data,
  input  logic       q_full
);

  cmd_t hold_r, hold_nxt;
  logic hold_vld_r, hold_vld_nxt;
  cmd_t cls;
  logic ignore;
  logic accept;

  // classify the item; a no-data item without end does nothing at all
  always_comb begin
    cls.data = in_data_byte;
    if (in_no_data) begin
      cls.kind = CMD_END;
    end else if (in_end_of_message) begin
      cls.kind = CMD_BYTE_END;
    end else begin
      cls.kind = CMD_BYTE;
    end
  end

  assign ignore = in_no_data & ~in_end_of_message;
  assign full   = hold_vld_r & q_full;
  assign accept = push & ~full;
  assign q_push = hold_vld_r & ~q_full;
  assign q_data = hold_r;

  always_comb begin
    hold_vld_nxt = (hold_vld_r & q_full) | (accept & ~ignore);
    hold_nxt     = accept ? cls : hold_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

endmodule

FILE: src/sha1md_queue.sv
`timescale 1ns / 1ps

module sha1md_queue
  import sha1md_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wr_data,
  output logic full,
  input  logic pop,
  output cmd_t rd_data,
  output logic empty
);

  localparam int AW = $clog2(DEPTH);

  cmd_t          mem_r [DEPTH];
  logic [AW:0]   wp_r, wp_nxt;
  logic [AW:0]   rp_r, rp_nxt;

  assign empty   = (wp_r == rp_r);
  assign full    = (wp_r[AW] != rp_r[AW]) && (wp_r[AW-1:0] == rp_r[AW-1:0]);
  assign rd_data = mem_r[rp_r[AW-1:0]];

  always_comb begin
    wp_nxt = (push && !full) ? wp_r + 1'b1 : wp_r;
    rp_nxt = (pop && !empty) ? rp_r + 1'b1 : rp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r[AW-1:0]] <= wr_data;
    end
  end

endmodule

FILE: src/sha1md_core.sv
`timescale 1ns / 1ps

module sha1md_core
  import sha1md_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_empty,
  input  cmd_t    q_data,
  output logic    q_pop,
  input  logic    ob_ready,
  output digest_t dig
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_START,
    ST_PAD,
    ST_PAD_NEXT,
    ST_COMP,
    ST_ADD,
    ST_DIGEST
  } state_t;

  localparam logic [DIGEST_WORDS-1:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_MARK = 8'h80;
  localparam logic [6:0]  LAST_ROUND = 7'd79;
  localparam logic [5:0]  LAST_POS = 6'd63;
  localparam logic [5:0]  LEN_POS = 6'd56;

  state_t state_r, state_nxt;
  state_t after_r, after_nxt;
  logic [60:0] cnt_r, cnt_nxt;
  logic [DIGEST_WORDS-1:0][31:0] h_r, h_nxt;
  logic [DIGEST_WORDS-1:0][31:0] rw_r, rw_nxt;
  logic [6:0] rnd_r, rnd_nxt;
  logic [5:0] pad_pos_r, pad_pos_nxt;
  logic pad_first_r, pad_first_nxt;
  logic len_blk_r, len_blk_nxt;
  logic [15:0][31:0] blk_r, blk_nxt;

  logic       wr_en;
  logic [5:0] wr_pos;
  logic [7:0] wr_byte;
  logic [4:0] lane_sh;
  logic [63:0] len_bits;
  logic [7:0] pad_byte;
  logic [31:0] a, b, c, d, e, w, f, k, t, wx;

  assign a = rw_r[0];
  assign b = rw_r[1];
  assign c = rw_r[2];
  assign d = rw_r[3];
  assign e = rw_r[4];

  // message schedule from a sixteen-word shift line
  assign wx = blk_r[13] ^ blk_r[8] ^ blk_r[2] ^ blk_r[0];
  assign w  = (rnd_r < 7'd16) ? blk_r[0] : {wx[30:0], wx[31]};

  always_comb begin
    if (rnd_r < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (rnd_r < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (rnd_r < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign t = {a[26:0], a[31:27]} + f + e + k + w;

  // padding byte: marker, zeros, then the big-endian bit length
  assign len_bits = {cnt_r, 3'b000};
  always_comb begin
    if (pad_first_r) begin
      pad_byte = PAD_MARK;
    end else if (len_blk_r && pad_pos_r >= LEN_POS) begin
      pad_byte = len_bits[{~pad_pos_r[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign q_pop = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    state_nxt     = state_r;
    after_nxt     = after_r;
    cnt_nxt       = cnt_r;
    h_nxt         = h_r;
    rw_nxt        = rw_r;
    rnd_nxt       = rnd_r;
    pad_pos_nxt   = pad_pos_r;
    pad_first_nxt = pad_first_r;
    len_blk_nxt   = len_blk_r;
    wr_en         = 1'b0;
    wr_pos        = cnt_r[5:0];
    wr_byte       = q_data.data;
    dig.valid     = 1'b0;
    dig.words     = h_r;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          case (q_data.kind)
            CMD_BYTE, CMD_BYTE_END: begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_r + 61'd1;
              if (cnt_r[5:0] == LAST_POS) begin
                state_nxt = ST_COMP;
                rw_nxt    = h_r;
                rnd_nxt   = '0;
                after_nxt = (q_data.kind == CMD_BYTE_END) ? ST_PAD_START : ST_IDLE;
              end else if (q_data.kind == CMD_BYTE_END) begin
                state_nxt = ST_PAD_START;
              end
            end
            CMD_END: begin
              state_nxt = ST_PAD_START;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_PAD_START: begin
        pad_pos_nxt   = cnt_r[5:0];
        pad_first_nxt = 1'b1;
        len_blk_nxt   = (cnt_r[5:0] < LEN_POS);
        state_nxt     = ST_PAD;
      end
      ST_PAD: begin
        wr_en         = 1'b1;
        wr_pos        = pad_pos_r;
        wr_byte       = pad_byte;
        pad_first_nxt = 1'b0;
        if (pad_pos_r == LAST_POS) begin
          state_nxt = ST_COMP;
          rw_nxt    = h_r;
          rnd_nxt   = '0;
          after_nxt = len_blk_r ? ST_DIGEST : ST_PAD_NEXT;
        end else begin
          pad_pos_nxt = pad_pos_r + 6'd1;
        end
      end
      ST_PAD_NEXT: begin
        // second padding block carries zeros and the length
        pad_pos_nxt   = '0;
        pad_first_nxt = 1'b0;
        len_blk_nxt   = 1'b1;
        state_nxt     = ST_PAD;
      end
      ST_COMP: begin
        rw_nxt[4] = d;
        rw_nxt[3] = c;
        rw_nxt[2] = {b[1:0], b[31:2]};
        rw_nxt[1] = a;
        rw_nxt[0] = t;
        rnd_nxt   = rnd_r + 7'd1;
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < DIGEST_WORDS; i++) begin
          h_nxt[i] = h_r[i] + rw_r[i];
        end
        state_nxt = after_r;
      end
      ST_DIGEST: begin
        if (ob_ready) begin
          dig.valid = 1'b1;
          h_nxt     = H_INIT;
          rw_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // block store: byte writes while filling, shift line while compressing
  assign lane_sh = {~wr_pos[1:0], 3'b000};
  always_comb begin
    blk_nxt = blk_r;
    if (state_r == ST_COMP) begin
      blk_nxt = {w, blk_r[15:1]};
    end else if (wr_en) begin
      blk_nxt[wr_pos[5:2]][lane_sh +: 8] = wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      after_r     <= ST_IDLE;
      cnt_r       <= '0;
      h_r         <= H_INIT;
      rw_r        <= '0;
      rnd_r       <= '0;
      pad_pos_r   <= '0;
      pad_first_r <= 1'b0;
      len_blk_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      after_r     <= after_nxt;
      cnt_r       <= cnt_nxt;
      h_r         <= h_nxt;
      rw_r        <= rw_nxt;
      rnd_r       <= rnd_nxt;
      pad_pos_r   <= pad_pos_nxt;
      pad_first_r <= pad_first_nxt;
      len_blk_r   <= len_blk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

endmodule

FILE: src/sha1md_outbuf.sv
`timescale 1ns / 1ps

module sha1md_outbuf
  import sha1md_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  digest_t     dig,
  output logic        ob_ready,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_number,
  output logic        out_last_word
);

  logic busy_r, busy_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [DIGEST_WORDS-1:0][31:0] words_r, words_nxt;

  assign ob_ready        = ~busy_r;
  assign empty           = ~busy_r;
  assign out_digest_word = words_r[0];
  assign out_word_number = idx_r;
  assign out_last_word   = (idx_r == LAST_WORD_NUM);

  always_comb begin
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    words_nxt = words_r;
    if (!busy_r) begin
      if (dig.valid) begin
        busy_nxt  = 1'b1;
        idx_nxt   = '0;
        words_nxt = dig.words;
      end
    end else if (pop) begin
      words_nxt = words_r >> 32;
      idx_nxt   = idx_r + 3'd1;
      if (idx_r == LAST_WORD_NUM) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    words_r <= words_nxt;
  end

endmodule

FILE: src/sha1_message_digest_unit.sv
`timescale 1ns / 1ps

// channel   | direction | handshake      | payload
// ----------+-----------+----------------+------------------------------------------------
// input     | in        | push / full    | in_data_byte, in_end_of_message, in_no_data
// result    | out       | empty / pop    | out_digest_word, out_word_number, out_last_word
//
// a byte item is written as it is popped; each full block then runs the 80 rounds
// and the chaining add, and no item is taken meanwhile
// a message end adds a setup state, a write per padding byte, rounds per padding block
// (a second block adds a setup state) and a digest hand-off; words leave one per pop
// synchronous active-low reset empties the queues and restores h0..h4
// full only with hold register and item queue both occupied; core waits on an unread digest

module sha1_message_digest_unit
  import sha1md_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_message,
  input  logic        in_no_data,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_number,
  output logic        out_last_word
);

  // front to queue
  logic    q_push;
  cmd_t    q_wr_data;
  logic    q_full;
  // queue to core
  logic    q_pop;
  cmd_t    q_rd_data;
  logic    q_empty;
  // core to output buffer
  digest_t dig;
  logic    ob_ready;

  // front: takes items, drops empty no-end items, classifies the rest
  sha1md_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .in_no_data        (in_no_data),
    .q_push            (q_push),
    .q_data            (q_wr_data),
    .q_full            (q_full)
  );

  // short command queue decoupling the front from the hashing core
  sha1md_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // core: byte packing, padding and the 80-round compression
  sha1md_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_rd_data),
    .q_pop    (q_pop),
    .ob_ready (ob_ready),
    .dig      (dig)
  );

  // output buffer: holds one digest and presents it a word at a time
  sha1md_outbuf u_outbuf (
    .clk             (clk),
    .rst_n           (rst_n),
    .dig             (dig),
    .ob_ready        (ob_ready),
    .empty           (empty),
    .pop             (pop),
    .out_digest_word (out_digest_word),
    .out_word_number (out_word_number),
    .out_last_word   (out_last_word)
  );

`ifndef SYNTHESIS
  // words of one digest come out in order with no gap
  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !out_last_word) |=>
      (!empty && out_word_number == $past(out_word_number) + 3'd1))
    else $error("digest word sequence broken");

  // the last-word flag marks word h4 only
  a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_last_word) |-> (out_word_number == LAST_WORD_NUM))
    else $error("last word flag on wrong word");

  // the front never pushes into a full item queue
  a_queue_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("item queue overflow");

  // a new digest is only handed over when the buffer is free
  a_dig_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    dig.valid |-> empty)
    else $error("digest handed over while buffer busy");
`endif

endmodule
